// File: design/pibox_pkg.sv
// shared constants and types for the point in oriented box test
`default_nettype none

package pibox_pkg;

	// default fixed-point formats
	localparam int COORD_BITS_DEF     = 20;
	localparam int AXIS_FRAC_BITS_DEF = 16;

	// configuration register widths
	localparam int CENTRE_REG_BITS = 60;
	localparam int AXIS_REG_BITS   = 54;
	localparam int HALF_REG_BITS   = 60;
	localparam int CFG_DATA_BITS   = 60;
	localparam int CFG_INDEX_BITS  = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_U = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_V = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_W = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HALF   = 3'd4;

	// load enables of the pipeline stages after the first
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

`default_nettype wire

// File: design/point_in_oriented_box_test.sv
// point in oriented box test, top level
//
// One 3-D point per request on the input channel (in_valid / in_stall) and
// one result per point on the output channel (out_valid / out_stall).
// The box is held in five configuration registers written through
// cfg_we / cfg_index / cfg_data: centre, axes u, v, w, and half extents.
// Write them only while no point is in flight.
// The pipeline has four register stages: centre subtract, nine axis
// products, three dot-product sums, and the strict extent compares.
// An accepted point moves through the subtract, product, sum and compare
// registers to the output; one point enters per cycle unless every stage is full.
// When the receiver stalls, the last stage holds its result and stages
// fill up behind it; in_stall rises only when every stage holds a point.
// Reset clears all valid bits and sets every configuration register to 0
// (zero half extents, so nothing is inside until configured).
`default_nettype none

module point_in_oriented_box_test
	import pibox_pkg::*;
#(
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]    cfg_data,
	// point requests
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [COORD_BITS-1:0] point_x,
	input  wire logic signed [COORD_BITS-1:0] point_y,
	input  wire logic signed [COORD_BITS-1:0] point_z,
	input  wire logic                        last_point,
	// result requests
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             inside_res,
	output logic                             last_result
);

	localparam int CW  = COORD_BITS;
	localparam int DW  = COORD_BITS + 1;
	localparam int EXW = 3 * CW + 64;

	logic [CENTRE_REG_BITS-1:0] centre_q;
	logic [AXIS_REG_BITS-1:0]   axis_u_q, axis_v_q, axis_w_q;
	logic [HALF_REG_BITS-1:0]   half_q;

	logic [EXW-1:0]       centre_ext;
	logic [EXW-1:0]       half_ext;
	logic signed [CW-1:0] cen_x, cen_y, cen_z;
	logic [CW-1:0]        half_u, half_v, half_w;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic                 adv1, adv2, adv3, adv4;
	stage_en_t            en;
	logic signed [DW-1:0] diff_x_s1, diff_y_s1, diff_z_s1;
	logic                 ok_u_s4, ok_v_s4, ok_w_s4;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= '0;
			axis_u_q <= '0;
			axis_v_q <= '0;
			axis_w_q <= '0;
			half_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTRE: centre_q <= cfg_data[CENTRE_REG_BITS-1:0];
				REG_AXIS_U: axis_u_q <= cfg_data[AXIS_REG_BITS-1:0];
				REG_AXIS_V: axis_v_q <= cfg_data[AXIS_REG_BITS-1:0];
				REG_AXIS_W: axis_w_q <= cfg_data[AXIS_REG_BITS-1:0];
				REG_HALF:   half_q   <= cfg_data[HALF_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// unpack centre and half extents, fields past the register read as zero
	assign centre_ext = EXW'(centre_q);
	assign half_ext   = EXW'(half_q);
	assign cen_x      = $signed(centre_ext[0 +: CW]);
	assign cen_y      = $signed(centre_ext[CW +: CW]);
	assign cen_z      = $signed(centre_ext[2*CW +: CW]);
	assign half_u     = half_ext[0 +: CW];
	assign half_v     = half_ext[CW +: CW];
	assign half_w     = half_ext[2*CW +: CW];

	// stage advance: a stage loads when empty or when the next one loads
	assign adv4     = !valid_s4 || !out_stall;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;
	assign en       = '{s2: adv2, s3: adv3, s4: adv4};

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: subtract the centre
	always_ff @(posedge clk) begin
		if (adv1) begin
			diff_x_s1 <= DW'(point_x) - DW'(cen_x);
			diff_y_s1 <= DW'(point_y) - DW'(cen_y);
			diff_z_s1 <= DW'(point_z) - DW'(cen_z);
			last_s1   <= last_point;
		end
	end

	// batch marker follows the point
	always_ff @(posedge clk) begin
		if (adv2) last_s2 <= last_s1;
		if (adv3) last_s3 <= last_s2;
		if (adv4) last_s4 <= last_s3;
	end

	// one projection unit per box axis
	pibox_axis #(
		.COORD_BITS     (COORD_BITS),
		.AXIS_FRAC_BITS (AXIS_FRAC_BITS)
	) u_axis_u (
		.clk         (clk),
		.en          (en),
		.diff_x_s1   (diff_x_s1),
		.diff_y_s1   (diff_y_s1),
		.diff_z_s1   (diff_z_s1),
		.axis_packed (axis_u_q),
		.half        (half_u),
		.ok_s4       (ok_u_s4)
	);

	pibox_axis #(
		.COORD_BITS     (COORD_BITS),
		.AXIS_FRAC_BITS (AXIS_FRAC_BITS)
	) u_axis_v (
		.clk         (clk),
		.en          (en),
		.diff_x_s1   (diff_x_s1),
		.diff_y_s1   (diff_y_s1),
		.diff_z_s1   (diff_z_s1),
		.axis_packed (axis_v_q),
		.half        (half_v),
		.ok_s4       (ok_v_s4)
	);

	pibox_axis #(
		.COORD_BITS     (COORD_BITS),
		.AXIS_FRAC_BITS (AXIS_FRAC_BITS)
	) u_axis_w (
		.clk         (clk),
		.en          (en),
		.diff_x_s1   (diff_x_s1),
		.diff_y_s1   (diff_y_s1),
		.diff_z_s1   (diff_z_s1),
		.axis_packed (axis_w_q),
		.half        (half_w),
		.ok_s4       (ok_w_s4)
	);

	// result
	assign out_valid   = valid_s4;
	assign inside_res  = ok_u_s4 & ok_v_s4 & ok_w_s4;
	assign last_result = last_s4;

endmodule

`default_nettype wire

// File: design/pibox_axis.sv
// projection of the centred point on one box axis and strict extent check
`default_nettype none

module pibox_axis
	import pibox_pkg::*;
#(
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire stage_en_t                    en,
	input  wire logic signed [COORD_BITS:0]   diff_x_s1,
	input  wire logic signed [COORD_BITS:0]   diff_y_s1,
	input  wire logic signed [COORD_BITS:0]   diff_z_s1,
	input  wire logic [AXIS_REG_BITS-1:0]     axis_packed,
	input  wire logic [COORD_BITS-1:0]        half,
	output logic                              ok_s4
);

	localparam int AW  = AXIS_FRAC_BITS + 2;
	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = DW + AW;
	localparam int SW  = PW + 2;
	localparam int EXW = 3 * AW + 64;

	logic [EXW-1:0]       axis_ext;
	logic signed [AW-1:0] ax_x, ax_y, ax_z;
	logic signed [PW-1:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [SW-1:0] dot_s3;
	logic signed [SW-1:0] bound;

	// axis components, fields past the register read as zero
	assign axis_ext = EXW'(axis_packed);
	assign ax_x     = $signed(axis_ext[0 +: AW]);
	assign ax_y     = $signed(axis_ext[AW +: AW]);
	assign ax_z     = $signed(axis_ext[2*AW +: AW]);

	// half extent scaled to the dot product format
	assign bound = $signed(SW'({half, {AXIS_FRAC_BITS{1'b0}}}));

	// stage 2: component products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_x_s2 <= PW'(diff_x_s1) * PW'(ax_x);
			prod_y_s2 <= PW'(diff_y_s1) * PW'(ax_y);
			prod_z_s2 <= PW'(diff_z_s1) * PW'(ax_z);
		end
	end

	// stage 3: dot product
	always_ff @(posedge clk) begin
		if (en.s3) begin
			dot_s3 <= SW'(prod_x_s2) + SW'(prod_y_s2) + SW'(prod_z_s2);
		end
	end

	// stage 4: strict two-sided compare
	always_ff @(posedge clk) begin
		if (en.s4) begin
			ok_s4 <= (dot_s3 < bound) && (dot_s3 > -bound);
		end
	end

endmodule

`default_nettype wire
